// ===== rtl/ssq_pkg.sv =====
// Package for the sorted sample quantile block.
// Holds default sizes, operation codes and read-mux grouping; no dependencies.
package ssq_pkg;

  localparam int SSQ_CAPACITY    = 1024;
  localparam int SSQ_SAMPLE_BITS = 16;

  localparam int CFG_W   = 11;
  localparam int PROB_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int RANK_W  = 10;
  localparam int FUNC_W  = 2;

  localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_QUANT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RANK  = 2'd2;

  localparam int RD_GROUP   = 32;
  localparam int RD_GROUP_W = 5;

endpackage

// ===== rtl/ssq_cell.sv =====
// One cell of the sorted insertion chain: holds one sample.
// Takes its left neighbor's sample or the new one on insert; no dependencies.
module ssq_cell #(
  parameter int INDEX       = 0,
  parameter int CNT_W       = 11,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          ins,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [CNT_W-1:0]       count,
  input  logic signed [SAMPLE_BITS-1:0] left_data,
  input  logic                          left_gt,
  output logic signed [SAMPLE_BITS-1:0] data,
  output logic                          gt
);

  logic occ;
  logic at_end;

  assign occ    = count > CNT_W'(INDEX);
  assign at_end = count == CNT_W'(INDEX);
  assign gt     = occ && (data > sample);

  always_ff @(posedge clk) begin
    if (ins) begin
      if (left_gt) begin
        data <= left_data;
      end else if (gt || at_end) begin
        data <= sample;
      end
    end
  end

endmodule

// ===== rtl/ssq_rd.sv =====
// Two-stage registered read mux over the cell chain.
// Selects within groups, then across groups; uses ssq_pkg.
module ssq_rd
  import ssq_pkg::*;
#(
  parameter int N = 1024,
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic [W-1:0]         data [N],
  input  logic [$clog2(N)-1:0] idx,
  output logic [W-1:0]         q
);

  localparam int NG    = (N + RD_GROUP - 1) / RD_GROUP;
  localparam int HI_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam int EXT_W = HI_W + RD_GROUP_W;

  logic [W-1:0]          pad [NG*RD_GROUP];
  logic [W-1:0]          grp [NG];
  logic [EXT_W-1:0]      idx_ext;
  logic [RD_GROUP_W-1:0] lo;
  logic [HI_W-1:0]       hi;
  logic [HI_W-1:0]       hi_r;

  assign idx_ext = EXT_W'(idx);
  assign lo      = idx_ext[RD_GROUP_W-1:0];
  assign hi      = idx_ext[EXT_W-1:RD_GROUP_W];

  for (genvar k = 0; k < NG*RD_GROUP; k++) begin : g_pad
    if (k < N) begin : g_real
      assign pad[k] = data[k];
    end else begin : g_zero
      assign pad[k] = '0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_ff @(posedge clk) begin
      grp[g] <= pad[g*RD_GROUP + int'(lo)];
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi;
    q    <= grp[hi_r];
  end

endmodule

// ===== rtl/sorted_sample_quantile.sv =====
// Sorted sample store with quantile and rank queries, built as a chain of cells.
// Add, func 3, empty quantile, bad rank: done is registered from EXEC; new items wait until idle.
// Rank passes EXEC, RD1, RD2 and INT before done; quantile too, plus SUM when interpolating.
// Queries wait on the two-stage read mux over the chain and the interpolation multiply.
// Synchronous reset clears count, full flag and limit; stored samples are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module sorted_sample_quantile
  import ssq_pkg::*;
#(
  parameter int CAPACITY    = SSQ_CAPACITY,
  parameter int SAMPLE_BITS = SSQ_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [FUNC_W-1:0]                     func,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [PROB_W-1:0]                     probability,
  input  logic [RANK_W-1:0]                     rank_index,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_W-1:0]                      cfg_data,
  output logic                                  done,
  output logic signed [SAMPLE_BITS+7:0]         value,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count,
  output logic                                  full_res,
  output logic                                  empty_res,
  output logic                                  rank_error
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int POS_W = CNT_W + PROB_W;
  localparam int SB    = SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_INT  = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   full;
  logic                   full_next;
  logic [CFG_W-1:0]       max_entries;

  logic [FUNC_W-1:0]      func_r;
  logic signed [SB-1:0]   sample_r;
  logic [PROB_W-1:0]      prob_r;
  logic [RANK_W-1:0]      rank_r;
  logic [POS_W-1:0]       pos;

  logic signed [SB+16:0]  prod0;
  logic signed [SB+16:0]  prod1;
  logic signed [SB+17:0]  sum;

  logic [CW-1:0]          lim;
  logic                   at_lim;
  logic                   ins;

  logic [CNT_W-1:0]       qi;
  logic [FRAC_W-1:0]      qf;
  logic                   use1;
  logic [IDX_W-1:0]       idx0;
  logic [IDX_W-1:0]       idx1;
  logic [PROB_W-1:0]      w0;

  logic [SB-1:0]          rd0_q;
  logic [SB-1:0]          rd1_q;
  logic signed [SB-1:0]   d0;
  logic signed [SB-1:0]   d1;

  logic                   fin;
  logic signed [SB+7:0]   fin_value;
  logic                   fin_err;

  logic signed [SB-1:0]   cell_q  [CAPACITY];
  logic [SB-1:0]          cell_u  [CAPACITY];
  logic                   cell_gt [CAPACITY];

  assign busy      = state != ST_IDLE;
  assign cfg_ready = !busy;

  // entry limit and insert decision
  assign lim = ((max_entries == '0) || (CW'(max_entries) > CW'(CAPACITY)))
             ? CW'(CAPACITY) : CW'(max_entries);
  assign at_lim = CW'(count) >= lim;

  always_comb begin
    full_next  = full;
    count_next = count;
    ins        = 1'b0;
    if (state == ST_EXEC && func_r == FN_ADD) begin
      full_next = full || at_lim;
      ins       = !full_next;
      if (ins) begin
        count_next = count + 1'b1;
      end
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [SB-1:0] left_data;
    logic                 left_gt;
    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_gt   = 1'b0;
    end else begin : g_rest
      assign left_data = cell_q[i-1];
      assign left_gt   = cell_gt[i-1];
    end
    ssq_cell #(
      .INDEX       (i),
      .CNT_W       (CNT_W),
      .SAMPLE_BITS (SB)
    ) u_cell (
      .clk       (clk),
      .ins       (ins),
      .sample    (sample_r),
      .count     (count),
      .left_data (left_data),
      .left_gt   (left_gt),
      .data      (cell_q[i]),
      .gt        (cell_gt[i])
    );
    assign cell_u[i] = cell_q[i];
  end

  // read addresses
  assign qi   = pos[CNT_W+FRAC_W-1:FRAC_W];
  assign qf   = pos[FRAC_W-1:0];
  assign use1 = (qf != '0) && ((CNT_W+1)'(qi) + 1'b1 < (CNT_W+1)'(count));
  assign idx0 = (func_r == FN_RANK) ? IDX_W'(rank_r) : IDX_W'(qi);
  assign idx1 = idx0 + 1'b1;
  assign w0   = PROB_ONE - PROB_W'(qf);

  ssq_rd #(.N(CAPACITY), .W(SB)) u_rd0 (
    .clk  (clk),
    .data (cell_u),
    .idx  (idx0),
    .q    (rd0_q)
  );

  ssq_rd #(.N(CAPACITY), .W(SB)) u_rd1 (
    .clk  (clk),
    .data (cell_u),
    .idx  (idx1),
    .q    (rd1_q)
  );

  assign d0  = rd0_q;
  assign d1  = rd1_q;
  assign sum = (SB+18)'(prod0) + (SB+18)'(prod1);

  // sequencer
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_value  = '0;
    fin_err    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (func_r)
          FN_ADD: begin
            fin        = 1'b1;
            state_next = ST_IDLE;
          end
          FN_QUANT: begin
            if (count == '0) begin
              fin        = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_RD1;
            end
          end
          FN_RANK: begin
            if (CW'(rank_r) >= CW'(count)) begin
              fin        = 1'b1;
              fin_err    = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_RD1;
            end
          end
          default: begin
            fin        = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_RD1: state_next = ST_RD2;
      ST_RD2: state_next = ST_INT;
      ST_INT: begin
        if (func_r == FN_QUANT && use1) begin
          state_next = ST_SUM;
        end else begin
          fin        = 1'b1;
          fin_value  = {d0, 8'd0};
          state_next = ST_IDLE;
        end
      end
      ST_SUM: begin
        fin        = 1'b1;
        fin_value  = sum[SB+15:8];
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      full        <= 1'b0;
      max_entries <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        max_entries <= cfg_data;
        full        <= (cfg_data != '0) && (CW'(count) > CW'(cfg_data));
      end else begin
        full <= full_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      func_r   <= func;
      sample_r <= sample;
      prob_r   <= (probability > PROB_ONE) ? PROB_ONE : probability;
      rank_r   <= rank_index;
    end
    if (state == ST_EXEC) begin
      pos <= POS_W'(count - 1'b1) * POS_W'(prob_r);
    end
    if (state == ST_INT) begin
      prod0 <= d0 * $signed({1'b0, w0[FRAC_W-1:0]});
      prod1 <= d1 * $signed({1'b0, qf});
    end
    if (fin) begin
      value       <= fin_value;
      entry_count <= count_next;
      full_res    <= full_next;
      empty_res   <= count_next == '0;
      rank_error  <= fin_err;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    CW'(count) <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rank_error) |-> (value == '0))
    else $error("rank error with nonzero value");

endmodule
